>>> rtl/core/tpq_pkg.sv
// Package: shared types and constants of the timeout priority queue.
`default_nettype none
package tpq_pkg;

    localparam int TPQ_CAPACITY = 64;

    localparam int TPQ_TIME_W = 64;
    localparam int TPQ_ID_W   = 32;
    localparam int TPQ_TYPE_W = 8;
    localparam int TPQ_INST_W = 64;
    localparam int TPQ_WAIT_W = 32;

    localparam logic [TPQ_ID_W-1:0]          TPQ_FIRST_SERIAL = 32'd1;
    localparam logic signed [TPQ_WAIT_W-1:0] TPQ_MAX_WAIT     = 32'sd2147483647;
    localparam logic signed [TPQ_WAIT_W-1:0] TPQ_WAIT_EMPTY   = -32'sd1;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_POP   = 2'd1,
        MODE_QUERY = 2'd2
    } tpq_mode_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NOT_DUE = 2'd3
    } tpq_status_t;

    typedef enum logic [1:0] {
        TPQ_HOLD,
        TPQ_PUSH,
        TPQ_POP
    } tpq_op_t;

    typedef struct packed {
        logic [TPQ_TIME_W-1:0] deadline;
        logic [TPQ_ID_W-1:0]   id;
        logic [TPQ_TYPE_W-1:0] ty;
        logic [TPQ_INST_W-1:0] inst;
    } tpq_entry_t;

    typedef struct packed {
        tpq_op_t    op;
        tpq_entry_t entry;
    } tpq_cmd_t;

endpackage
`default_nettype wire

>>> rtl/core/tpq_if.sv
// Interfaces: request and response channels of the timeout priority queue.
`default_nettype none
interface tpq_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   mode;
    logic [tpq_pkg::TPQ_TIME_W-1:0] due_time;
    logic [tpq_pkg::TPQ_TYPE_W-1:0] type_tag;
    logic [tpq_pkg::TPQ_INST_W-1:0] instance_req;
    logic [tpq_pkg::TPQ_TIME_W-1:0] now_ms;

    modport source (output valid, mode, due_time, type_tag, instance_req, now_ms,
                    input ready);
    modport sink   (input valid, mode, due_time, type_tag, instance_req, now_ms,
                    output ready);
endinterface

interface tpq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic [tpq_pkg::TPQ_ID_W-1:0]        timer_id;
    logic [tpq_pkg::TPQ_TYPE_W-1:0]      out_type;
    logic [tpq_pkg::TPQ_INST_W-1:0]      out_instance;
    logic signed [tpq_pkg::TPQ_WAIT_W-1:0] next_timeout;

    modport source (output valid, status, timer_id, out_type, out_instance, next_timeout,
                    input ready);
    modport sink   (input valid, status, timer_id, out_type, out_instance, next_timeout,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/core/timeout_priority_queue_unit.sv
// Top level: timer queue ordered by deadline, built as a chain of sorting cells.
//
// The unit accepts one request word per clock and answers each with one
// response word, registered, in the following cycle; a new request is taken
// while the previous response waits as long as that response is taken in the
// same cycle. Entries live in a chain of CAPACITY cells kept sorted by
// deadline, then by id; an add compares the new entry against every cell at
// once and each cell either holds, takes the new entry or takes its upper
// neighbor's, and a pop shifts every cell up by one. The critical path is one
// 96-bit deadline/id compare per cell plus the 64-bit subtract and saturation
// of the query answer. Ids count from 1 modulo 2^32; an add to a full queue
// returns status full and uses no id.
`default_nettype none
module timeout_priority_queue_unit
    import tpq_pkg::*;
#(
    parameter int CAPACITY = TPQ_CAPACITY
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    tpq_req_if.sink   req,
    tpq_rsp_if.source rsp
);

    logic       cell_valid [CAPACITY];
    tpq_entry_t cell_entry [CAPACITY];
    logic       cell_ahead [CAPACITY];
    tpq_cmd_t   cmd;

    logic [TPQ_ID_W-1:0] serial_reg;
    logic [TPQ_ID_W-1:0] serial_next;

    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    logic [1:0]                    status_reg;
    logic [1:0]                    status_next;
    logic [TPQ_ID_W-1:0]           timer_id_reg;
    logic [TPQ_ID_W-1:0]           timer_id_next;
    logic [TPQ_TYPE_W-1:0]         out_type_reg;
    logic [TPQ_TYPE_W-1:0]         out_type_next;
    logic [TPQ_INST_W-1:0]         out_instance_reg;
    logic [TPQ_INST_W-1:0]         out_instance_next;
    logic signed [TPQ_WAIT_W-1:0]  next_timeout_reg;
    logic signed [TPQ_WAIT_W-1:0]  next_timeout_next;

    logic                  accept;
    logic                  head_valid;
    tpq_entry_t            head;
    logic                  full;
    logic                  head_due;
    logic [TPQ_TIME_W-1:0] diff;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                tpq_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .cmd        (cmd),
                    .prev_valid (1'b0),
                    .prev_entry (cmd.entry),
                    .prev_ahead (1'b0),
                    .next_valid (cell_valid[gi+1]),
                    .next_entry (cell_entry[gi+1]),
                    .valid      (cell_valid[gi]),
                    .entry      (cell_entry[gi]),
                    .ahead      (cell_ahead[gi])
                );
            end
            else if (gi == CAPACITY - 1)
            begin : g_last
                tpq_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .cmd        (cmd),
                    .prev_valid (cell_valid[gi-1]),
                    .prev_entry (cell_entry[gi-1]),
                    .prev_ahead (cell_ahead[gi-1]),
                    .next_valid (1'b0),
                    .next_entry (cmd.entry),
                    .valid      (cell_valid[gi]),
                    .entry      (cell_entry[gi]),
                    .ahead      (cell_ahead[gi])
                );
            end
            else
            begin : g_mid
                tpq_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .cmd        (cmd),
                    .prev_valid (cell_valid[gi-1]),
                    .prev_entry (cell_entry[gi-1]),
                    .prev_ahead (cell_ahead[gi-1]),
                    .next_valid (cell_valid[gi+1]),
                    .next_entry (cell_entry[gi+1]),
                    .valid      (cell_valid[gi]),
                    .entry      (cell_entry[gi]),
                    .ahead      (cell_ahead[gi])
                );
            end
        end
    endgenerate

    assign req.ready  = !rsp_valid_reg || rsp.ready;
    assign accept     = req.valid && req.ready;
    assign head_valid = cell_valid[0];
    assign head       = cell_entry[0];
    assign full       = cell_valid[CAPACITY-1];
    assign head_due   = head.deadline <= req.now_ms;
    assign diff       = head.deadline - req.now_ms;

    always_comb
    begin
        cmd.op             = TPQ_HOLD;
        cmd.entry.deadline = req.due_time;
        cmd.entry.id       = serial_reg;
        cmd.entry.ty       = req.type_tag;
        cmd.entry.inst     = req.instance_req;

        serial_next        = serial_reg;
        status_next        = ST_DONE;
        timer_id_next      = '0;
        out_type_next      = '0;
        out_instance_next  = '0;
        next_timeout_next  = '0;

        case (req.mode)
            MODE_ADD:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.op        = accept ? TPQ_PUSH : TPQ_HOLD;
                    serial_next   = accept ? serial_reg + 1'b1 : serial_reg;
                    timer_id_next = serial_reg;
                end
            end
            MODE_POP:
            begin
                if (!head_valid)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!head_due)
                begin
                    status_next = ST_NOT_DUE;
                end
                else
                begin
                    cmd.op            = accept ? TPQ_POP : TPQ_HOLD;
                    timer_id_next     = head.id;
                    out_type_next     = head.ty;
                    out_instance_next = head.inst;
                end
            end
            MODE_QUERY:
            begin
                if (!head_valid)
                begin
                    status_next       = ST_EMPTY;
                    next_timeout_next = TPQ_WAIT_EMPTY;
                end
                else if (!head_due)
                begin
                    if (diff > TPQ_TIME_W'(TPQ_MAX_WAIT))
                    begin
                        next_timeout_next = TPQ_MAX_WAIT;
                    end
                    else
                    begin
                        next_timeout_next = $signed(diff[TPQ_WAIT_W-1:0]);
                    end
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            serial_reg    <= TPQ_FIRST_SERIAL;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            serial_reg    <= serial_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg       <= status_next;
            timer_id_reg     <= timer_id_next;
            out_type_reg     <= out_type_next;
            out_instance_reg <= out_instance_next;
            next_timeout_reg <= next_timeout_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.timer_id     = timer_id_reg;
    assign rsp.out_type     = out_type_reg;
    assign rsp.out_instance = out_instance_reg;
    assign rsp.next_timeout = next_timeout_reg;

endmodule
`default_nettype wire

>>> rtl/core/tpq_cell.sv
// Queue cell: one sorted slot that takes a new entry or a neighbor's entry.
`default_nettype none
module tpq_cell
    import tpq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire tpq_cmd_t   cmd,
    input  wire logic       prev_valid,
    input  wire tpq_entry_t prev_entry,
    input  wire logic       prev_ahead,
    input  wire logic       next_valid,
    input  wire tpq_entry_t next_entry,
    output logic            valid,
    output tpq_entry_t      entry,
    output logic            ahead
);

    logic       valid_reg;
    logic       valid_next;
    tpq_entry_t entry_reg;
    tpq_entry_t entry_next;

    always_comb
    begin
        ahead = !valid_reg
             || (cmd.entry.deadline < entry_reg.deadline)
             || ((cmd.entry.deadline == entry_reg.deadline)
                 && (cmd.entry.id < entry_reg.id));
    end

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        case (cmd.op)
            TPQ_PUSH:
            begin
                if (ahead)
                begin
                    // shift down when the new word belongs further up
                    if (prev_ahead)
                    begin
                        valid_next = prev_valid;
                        entry_next = prev_entry;
                    end
                    else
                    begin
                        valid_next = 1'b1;
                        entry_next = cmd.entry;
                    end
                end
            end
            TPQ_POP:
            begin
                valid_next = next_valid;
                entry_next = next_entry;
            end
            default:
            begin
                valid_next = valid_reg;
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule
`default_nettype wire

>>> test/tb_timeout_priority_queue_unit.sv
// Testbench: timer queue unit checked word by word against a sorted-queue predictor.
`default_nettype none
module tb_timeout_priority_queue_unit;
    import tpq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 300000;
    localparam int RANDOM_WORDS = 1250;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_GAP = 13;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [TPQ_TIME_W-1:0] TIME_MAX = '1;

    typedef enum {EP_FILL, EP_DRAIN, EP_NOISE, EP_MIXED} episode_t;

    typedef struct {
        tpq_status_t                  status;
        logic [TPQ_ID_W-1:0]          id;
        logic [TPQ_TYPE_W-1:0]        ty;
        logic [TPQ_INST_W-1:0]        inst;
        logic signed [TPQ_WAIT_W-1:0] wait_ms;
    } timer_reply_t;

    class timer_scoreboard;
        tpq_entry_t          held[$];
        logic [TPQ_ID_W-1:0] serial;
        timer_reply_t        awaited[$];
        int                  errors;

        function new();
            serial = TPQ_FIRST_SERIAL;
            errors = 0;
        endfunction

        function bit goes_first(tpq_entry_t a, tpq_entry_t b);
            if (a.deadline != b.deadline)
                return a.deadline < b.deadline;
            return a.id < b.id;
        endfunction

        function timer_reply_t serve(logic [1:0] mode, logic [TPQ_TIME_W-1:0] due,
                                     logic [TPQ_TYPE_W-1:0] ty,
                                     logic [TPQ_INST_W-1:0] inst,
                                     logic [TPQ_TIME_W-1:0] now);
            timer_reply_t          r;
            tpq_entry_t            e;
            logic [TPQ_TIME_W-1:0] left;
            int                    pos;
            r.status = ST_DONE;
            r.id = '0;
            r.ty = '0;
            r.inst = '0;
            r.wait_ms = '0;
            case (mode)
                MODE_ADD:
                begin
                    if (held.size() >= TPQ_CAPACITY)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        e.deadline = due;
                        e.id = serial;
                        e.ty = ty;
                        e.inst = inst;
                        serial = serial + 1'b1;
                        pos = 0;
                        while (pos < held.size() && !goes_first(e, held[pos]))
                            pos++;
                        held.insert(pos, e);
                        r.id = e.id;
                    end
                end
                MODE_POP:
                begin
                    if (held.size() == 0)
                        r.status = ST_EMPTY;
                    else if (held[0].deadline > now)
                        r.status = ST_NOT_DUE;
                    else
                    begin
                        e = held.pop_front();
                        r.id = e.id;
                        r.ty = e.ty;
                        r.inst = e.inst;
                    end
                end
                MODE_QUERY:
                begin
                    if (held.size() == 0)
                    begin
                        r.status = ST_EMPTY;
                        r.wait_ms = TPQ_WAIT_EMPTY;
                    end
                    else if (held[0].deadline > now)
                    begin
                        left = held[0].deadline - now;
                        if (left > $unsigned(TPQ_MAX_WAIT))
                            r.wait_ms = TPQ_MAX_WAIT;
                        else
                            r.wait_ms = left[TPQ_WAIT_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
            return r;
        endfunction

        function void note_request(logic [1:0] mode, logic [TPQ_TIME_W-1:0] due,
                                   logic [TPQ_TYPE_W-1:0] ty,
                                   logic [TPQ_INST_W-1:0] inst,
                                   logic [TPQ_TIME_W-1:0] now);
            awaited = {awaited, serve(mode, due, ty, inst, now)};
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_response(logic [1:0] status, logic [TPQ_ID_W-1:0] id,
                            logic [TPQ_TYPE_W-1:0] ty, logic [TPQ_INST_W-1:0] inst,
                            logic signed [TPQ_WAIT_W-1:0] wait_ms);
            timer_reply_t want;
            if (awaited.size() == 0)
            begin
                report("response word with nothing awaited");
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status)
                report($sformatf("status got %0d want %0d", status, want.status));
            if (id !== want.id)
                report($sformatf("timer_id got %0h want %0h", id, want.id));
            if (ty !== want.ty)
                report($sformatf("out_type got %0h want %0h", ty, want.ty));
            if (inst !== want.inst)
                report($sformatf("out_instance got %0h want %0h", inst, want.inst));
            if (wait_ms !== want.wait_ms)
                report($sformatf("next_timeout got %0d want %0d", wait_ms, want.wait_ms));
        endtask

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   tx_steady;
    bit   rx_steady;
    int   rx_count;
    int   cycle_count;

    timer_scoreboard sb = new();

    tpq_req_if req ();
    tpq_rsp_if rsp ();

    timeout_priority_queue_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task send_word(logic [1:0] mode, logic [TPQ_TIME_W-1:0] due,
                   logic [TPQ_TYPE_W-1:0] ty, logic [TPQ_INST_W-1:0] inst,
                   logic [TPQ_TIME_W-1:0] now);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.mode         <= mode;
        req.due_time     <= due;
        req.type_tag     <= ty;
        req.instance_req <= inst;
        req.now_ms       <= now;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // track accepted words on both sides
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
                sb.note_request(req.mode, req.due_time, req.type_tag, req.instance_req,
                                req.now_ms);
            if (rsp.valid && rsp.ready)
                sb.check_response(rsp.status, rsp.timer_id, rsp.out_type, rsp.out_instance,
                                  rsp.next_timeout);
        end
    end

    initial
    begin
        int gap;
        rsp.ready <= 1'b0;
        rx_count = 0;
        rx_steady = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rx_count % 50 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
            if (rx_count == 300 || rx_count == 900)
            begin
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
                if (gap != 0)
                begin
                    rsp.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
                @(posedge clk);
            rx_count++;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_timeout_priority_queue_unit: done, errors");
        $finish;
    end

    initial
    begin
        logic [TPQ_TIME_W-1:0] base;
        logic [TPQ_TIME_W-1:0] due;
        logic [TPQ_TIME_W-1:0] now;
        logic [TPQ_TIME_W-1:0] edge_due;
        logic [1:0]            mode;
        episode_t              kind;
        int                    sent;
        int                    len;
        int                    pick;

        rst_n            <= 1'b0;
        req.valid        <= 1'b0;
        req.mode         <= MODE_ADD;
        req.due_time     <= '0;
        req.type_tag     <= '0;
        req.instance_req <= '0;
        req.now_ms       <= '0;
        tx_steady = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        edge_due = 64'($unsigned(TPQ_MAX_WAIT)) + 64'd10;
        send_word(MODE_POP, '0, '0, '0, '0);
        send_word(MODE_QUERY, '0, '0, '0, '0);
        send_word(MODE_UNUSED, TIME_MAX, '1, TIME_MAX, TIME_MAX);
        send_word(MODE_ADD, '0, '0, '0, TIME_MAX);
        send_word(MODE_ADD, TIME_MAX, '1, TIME_MAX, '0);
        send_word(MODE_ADD, 64'd1000, 8'h5A, rand64(), '0);
        send_word(MODE_ADD, 64'd1000, 8'hA5, rand64(), '0);
        send_word(MODE_QUERY, '0, '0, '0, '0);
        send_word(MODE_POP, '0, '0, '0, '0);
        send_word(MODE_QUERY, '0, '0, '0, '0);
        send_word(MODE_QUERY, '0, '0, '0, 64'd2000);
        send_word(MODE_POP, '0, '0, '0, 64'd999);
        send_word(MODE_POP, '0, '0, '0, 64'd1000);
        send_word(MODE_POP, '0, '0, '0, 64'd1000);
        send_word(MODE_ADD, edge_due, 8'h3C, rand64(), '0);
        send_word(MODE_QUERY, '0, '0, '0, 64'd10);
        send_word(MODE_QUERY, '0, '0, '0, 64'd9);
        send_word(MODE_QUERY, '0, '0, '0, 64'd11);
        send_word(MODE_QUERY, '0, '0, '0, '0);
        send_word(MODE_POP, '0, '0, '0, TIME_MAX);
        send_word(MODE_POP, '0, '0, '0, TIME_MAX - 64'd1);
        send_word(MODE_POP, '0, '0, '0, TIME_MAX);
        send_word(MODE_POP, '0, '0, '0, TIME_MAX);
        send_word(MODE_QUERY, '0, '0, '0, TIME_MAX);

        base = '0;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 9);
            kind = (pick == 0) ? EP_FILL : (pick == 1) ? EP_DRAIN :
                   (pick == 2) ? EP_NOISE : EP_MIXED;
            len = (kind == EP_FILL || kind == EP_DRAIN) ? 70 : $urandom_range(16, 40);
            tx_steady = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 7);
            if (pick == 0)
                base = rand64();
            else if (pick == 1)
                base = 64'($urandom_range(0, 1000));
            for (int k = 0; k < len; k++)
            begin
                due = rand64();
                now = rand64();
                case (kind)
                    EP_FILL:
                    begin
                        mode = MODE_ADD;
                        due = base + 64'($urandom_range(0, 40));
                    end
                    EP_DRAIN:
                    begin
                        mode = MODE_POP;
                        now = TIME_MAX;
                    end
                    EP_NOISE:
                    begin
                        mode = 2'($urandom_range(0, 3));
                    end
                    default:
                    begin
                        pick = $urandom_range(0, 19);
                        mode = (pick < 8) ? MODE_ADD : (pick < 15) ? MODE_POP :
                               (pick < 19) ? MODE_QUERY : MODE_UNUSED;
                        if ($urandom_range(0, 9) != 0)
                            due = base + 64'($urandom_range(0, 150));
                        now = base + 64'($urandom_range(0, 150));
                    end
                endcase
                send_word(mode, due, 8'($urandom_range(0, 255)), rand64(), now);
                base = base + 64'($urandom_range(0, 16));
            end
            sent += len;
        end
        req.valid <= 1'b0;

        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.pending() != 0)
            sb.report("responses still awaited at end");
        if (sb.errors == 0)
            $display("tb_timeout_priority_queue_unit: done, clean");
        else
            $display("tb_timeout_priority_queue_unit: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
